// ===== design/bis_pkg.sv =====
// Shared types and constants for the bicubic image scaler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

  // Field widths
  localparam int COORD_W  = 12;
  localparam int SAMPLE_W = 8;
  localparam int SIZE_W   = 9;
  localparam int STEP_W   = 25;
  localparam int CFG_W    = 25;
  localparam int CFG_IDX_W = 2;

  // Fixed-point widths: Q14 weights, integer source position
  localparam int WGT_W  = 16;
  localparam int BASE_W = 22;
  localparam int POS_W  = 23;
  localparam int PROD_W = 2 * WGT_W;
  localparam int SUM_W  = 44;

  // Default store size
  localparam int DEF_MAX_SRC_WIDTH  = 256;
  localparam int DEF_MAX_SRC_HEIGHT = 256;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 2'd3;

  // Register reset values
  localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = 9'd256;
  localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = 9'd256;
  localparam logic [STEP_W-1:0] RST_STEP       = 25'd65536;

  // Item codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  typedef struct packed {
    logic                func;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [SAMPLE_W-1:0] sample;
  } bis_item_t;

  typedef logic signed [WGT_W-1:0] wgt_t;

endpackage

`default_nettype wire

// ===== design/bis_front.sv =====
// Front end: accepts input items and holds them in a two-entry queue.
// Depends on bis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bis_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  bis_pkg::bis_item_t     in_item,
  output logic                         q_valid,
  input  wire                          q_pop,
  output bis_pkg::bis_item_t           q_item
);
  import bis_pkg::*;

  bis_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  // Store incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/bis_axis.sv =====
// Axis setup: maps one destination coordinate to a source base index and
// four Keys cubic weights in Q14. Depends on bis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bis_axis (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  input  wire  [bis_pkg::COORD_W-1:0]           coord,
  input  wire  [bis_pkg::STEP_W-1:0]            step,
  output logic                                  done,
  output logic signed [bis_pkg::BASE_W-1:0]     base,
  output bis_pkg::wgt_t                         wgt [4]
);
  import bis_pkg::*;

  localparam int MUL_W = COORD_W + 1 + STEP_W;
  localparam int P_W   = MUL_W + 1;
  localparam int N_W   = 54;

  logic [3:0]              vld;
  logic signed [P_W-1:0]   p;
  logic [15:0]             t;
  logic [31:0]             t2;
  logic [47:0]             t3;
  logic [MUL_W-1:0]        mul;
  logic signed [N_W-1:0]   a3, a2, a1, n0, n1, n2, n3;

  assign mul  = {(COORD_W + 1 - 1)'(0), coord, 1'b1} * MUL_W'(step);
  assign done = vld[3];
  assign base = p[P_W-1:17];

  // Q48 terms
  assign a3 = N_W'(t3);
  assign a2 = N_W'({t2, 16'd0});
  assign a1 = N_W'({t, 32'd0});
  assign n0 = -a3 + (a2 <<< 1) - a1;
  assign n1 = 3 * a3 - 5 * a2 + (N_W'(1) <<< 49);
  assign n2 = -3 * a3 + (a2 <<< 2) + a1;
  assign n3 = a3 - a2;

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 4'd0;
    end else begin
      vld <= {vld[2:0], start};
    end
  end

  // Position, fraction powers, then weights rounded half up
  always_ff @(posedge clk) begin
    if (start) begin
      p <= $signed({1'b0, mul}) - P_W'(65536);
    end
    if (vld[0]) begin
      t  <= p[16:1];
      t2 <= 32'(p[16:1]) * 32'(p[16:1]);
    end
    if (vld[1]) begin
      t3 <= 48'(t2) * 48'(t);
    end
    if (vld[2]) begin
      wgt[0] <= wgt_t'((n0 + (N_W'(1) <<< 34)) >>> 35);
      wgt[1] <= wgt_t'((n1 + (N_W'(1) <<< 34)) >>> 35);
      wgt[2] <= wgt_t'((n2 + (N_W'(1) <<< 34)) >>> 35);
      wgt[3] <= wgt_t'((n3 + (N_W'(1) <<< 34)) >>> 35);
    end
  end

endmodule

`default_nettype wire

// ===== design/bis_back.sv =====
// Back end: frame store, axis setup, 4x4 fetch and multiply-accumulate,
// output register. Depends on bis_pkg and bis_axis.
`timescale 1ns / 1ps
`default_nettype none

module bis_back #(
  parameter int MAX_SRC_WIDTH  = bis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = bis_pkg::DEF_MAX_SRC_HEIGHT
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             q_valid,
  output logic                            q_pop,
  input  wire  bis_pkg::bis_item_t        q_item,
  input  wire  [bis_pkg::SIZE_W-1:0]      src_width,
  input  wire  [bis_pkg::SIZE_W-1:0]      src_height,
  input  wire  [bis_pkg::STEP_W-1:0]      x_step,
  input  wire  [bis_pkg::STEP_W-1:0]      y_step,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [bis_pkg::SAMPLE_W-1:0]    pixel,
  output logic [bis_pkg::COORD_W-1:0]     out_col,
  output logic [bis_pkg::COORD_W-1:0]     out_row
);
  import bis_pkg::*;

  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_SRC_WIDTH);
  localparam int YW    = $clog2(MAX_SRC_HEIGHT);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SETUP  = 5'b00010,
    ST_FETCH  = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [SAMPLE_W-1:0]      mem [DEPTH];
  logic [COORD_W-1:0]       cur_col, cur_row;
  logic [3:0]               k;
  logic                     axis_start, x_done, y_done;
  logic signed [BASE_W-1:0] bx, by;
  wgt_t                     wx [4];
  wgt_t                     wy [4];

  logic signed [POS_W-1:0]  sw, sh, vx, vy;
  logic [XW-1:0]            px;
  logic [YW-1:0]            py;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic                     load_ok, mem_we, issue;

  logic                     rd_v, prod_v;
  logic [SAMPLE_W-1:0]      rd_data;
  logic signed [PROD_W-1:0] wprod;
  logic signed [SUM_W-1:0]  prod, sum, rnd;
  logic [SAMPLE_W-1:0]      pix_val;

  assign q_pop      = (state == ST_IDLE) && q_valid;
  assign axis_start = q_pop && (q_item.func == FUNC_COMPUTE);
  assign issue      = (state == ST_FETCH);

  bis_axis u_axis_x (
    .clk(clk), .rst(rst), .start(axis_start), .coord(q_item.col), .step(x_step),
    .done(x_done), .base(bx), .wgt(wx)
  );
  bis_axis u_axis_y (
    .clk(clk), .rst(rst), .start(axis_start), .coord(q_item.row), .step(y_step),
    .done(y_done), .base(by), .wgt(wy)
  );

  // Effective sizes: zero reads as one, oversize reads as the store size
  always_comb begin
    sw = POS_W'(src_width);
    sh = POS_W'(src_height);
    if (src_width == '0) begin
      sw = POS_W'(1);
    end else if (sw > POS_W'(MAX_SRC_WIDTH)) begin
      sw = POS_W'(MAX_SRC_WIDTH);
    end
    if (src_height == '0) begin
      sh = POS_W'(1);
    end else if (sh > POS_W'(MAX_SRC_HEIGHT)) begin
      sh = POS_W'(MAX_SRC_HEIGHT);
    end
  end

  // Clamp neighbour indices at the plane edges
  always_comb begin
    vx = POS_W'(bx) + POS_W'({1'b0, k[1:0]}) - POS_W'(1);
    vy = POS_W'(by) + POS_W'({1'b0, k[3:2]}) - POS_W'(1);
    if (vx < 0) begin
      px = '0;
    end else if (vx >= sw) begin
      px = XW'(sw - POS_W'(1));
    end else begin
      px = XW'(vx);
    end
    if (vy < 0) begin
      py = '0;
    end else if (vy >= sh) begin
      py = YW'(sh - POS_W'(1));
    end else begin
      py = YW'(vy);
    end
  end

  assign rd_addr = AW'(py) * AW'(MAX_SRC_WIDTH) + AW'(px);
  assign wr_addr = AW'(q_item.row) * AW'(MAX_SRC_WIDTH) + AW'(q_item.col);
  assign load_ok = ({1'b0, q_item.col} < (COORD_W + 1)'(MAX_SRC_WIDTH)) &&
                   ({1'b0, q_item.row} < (COORD_W + 1)'(MAX_SRC_HEIGHT));
  assign mem_we  = q_pop && (q_item.func == FUNC_LOAD) && load_ok;

  // Frame store: one port, write on load, read on fetch
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_item.sample;
    end else if (issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Weight product alongside the read, then sample product
  always_ff @(posedge clk) begin
    if (issue) begin
      wprod <= PROD_W'(wy[k[3:2]]) * PROD_W'(wx[k[1:0]]);
    end
    if (rd_v) begin
      prod <= SUM_W'($signed({1'b0, rd_data})) * SUM_W'(wprod);
    end
  end

  // Round, clip at zero and 255
  always_comb begin
    rnd = (sum + (SUM_W'(1) <<< 27)) >>> 28;
    if (sum <= 0) begin
      pix_val = '0;
    end else if (rnd > SUM_W'(255)) begin
      pix_val = 8'd255;
    end else begin
      pix_val = SAMPLE_W'(rnd);
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (axis_start) state_next = ST_SETUP;
      ST_SETUP:  if (x_done && y_done) state_next = ST_FETCH;
      ST_FETCH:  if (k == 4'd15) state_next = ST_DRAIN;
      ST_DRAIN:  if (!rd_v && !prod_v) state_next = ST_FINISH;
      ST_FINISH: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_v   <= issue;
      prod_v <= rd_v;
      if (issue) begin
        k <= k + 4'd1;
      end else begin
        k <= '0;
      end
      if (state == ST_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: coordinates, accumulator, result
  always_ff @(posedge clk) begin
    if (axis_start) begin
      cur_col <= q_item.col;
      cur_row <= q_item.row;
    end
    if (state == ST_SETUP) begin
      sum <= '0;
    end else if (prod_v) begin
      sum <= sum + prod;
    end
    if (state == ST_FINISH && (!out_valid || !out_stall)) begin
      pixel   <= pix_val;
      out_col <= cur_col;
      out_row <= cur_row;
    end
  end

endmodule

`default_nettype wire

// ===== design/bicubic_image_scaler.sv =====
// Bicubic image scaler (Keys kernel, half-pixel centres), top level.
// Flow: a compute item leaving the queue goes through axis setup, 4x4 frame-store reads
// on the single port, pipe drain and the output register load. One load item per cycle
// while the back end is idle; one item at a time behind a two-entry queue, a compute item
// finished before another is taken; a result held by the output stall holds the back end.
// Reset clears control state and sets registers to 256, 256, 1.0, 1.0; store not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bicubic_image_scaler #(
  parameter int MAX_SRC_WIDTH  = bis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = bis_pkg::DEF_MAX_SRC_HEIGHT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_write,
  input  wire  [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [bis_pkg::CFG_W-1:0]        cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              func,
  input  wire  [bis_pkg::COORD_W-1:0]      col,
  input  wire  [bis_pkg::COORD_W-1:0]      row,
  input  wire  [bis_pkg::SAMPLE_W-1:0]     sample,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [bis_pkg::SAMPLE_W-1:0]     pixel,
  output logic [bis_pkg::COORD_W-1:0]      out_col,
  output logic [bis_pkg::COORD_W-1:0]      out_row
);
  import bis_pkg::*;

  logic [SIZE_W-1:0] src_width, src_height;
  logic [STEP_W-1:0] x_step, y_step;
  bis_item_t         in_item, q_item;
  logic              q_valid, q_pop;

  assign in_item = '{func: func, col: col, row: row, sample: sample};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= RST_SRC_WIDTH;
      src_height <= RST_SRC_HEIGHT;
      x_step     <= RST_STEP;
      y_step     <= RST_STEP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SIZE_W-1:0];
        REG_X_STEP:     x_step     <= cfg_data[STEP_W-1:0];
        REG_Y_STEP:     y_step     <= cfg_data[STEP_W-1:0];
        default:        ;
      endcase
    end
  end

  bis_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  bis_back #(
    .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .src_width(src_width), .src_height(src_height),
    .x_step(x_step), .y_step(y_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel(pixel), .out_col(out_col), .out_row(out_row)
  );

endmodule

`default_nettype wire
